[hdl/assert_macros.svh]
// Assertion helpers shared by the npd modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("npd assertion failed");

// next-cycle implication
`define NPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("npd assertion failed");

`endif

[hdl/npd_pkg.sv]
package npd_pkg;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       start_of_file;
      logic       end_of_file;
   } req_word_type;

   typedef struct packed {
      logic [15:0] column;
      logic [15:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [2:0]  image_kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last_in_run;
      logic        image_complete;
   } rsp_word_type;

   // what the parse of one byte leaves to do
   typedef enum logic [1:0] {
      WORK_NONE,
      WORK_DIRECT,
      WORK_SCALE,
      WORK_RUN
   } work_type;

   typedef struct packed {
      logic capture;
      logic parse;
      logic div_step;
      logic place;
      logic finish;
   } cmd_type;

   typedef struct packed {
      work_type work;
      logic     div_last;
      logic     emitted;
      logic     more;
   } status_type;

endpackage

[hdl/npd_ifs.sv]
interface npd_req_if;
   logic                  valid;
   logic                  ready;
   npd_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface npd_rsp_if;
   logic                  valid;
   logic                  ready;
   npd_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

[hdl/npd_ctrl.sv]
`include "assert_macros.svh"

module npd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  npd_pkg::status_type st,
   output npd_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_WAIT,
      S_PARSE,
      S_DIVIDE,
      S_PLACE,
      S_SEND,
      S_END
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
      end else begin
         case (state_ff)
            S_WAIT: begin
               if (req_valid) state_ff <= S_PARSE;
            end
            S_PARSE: begin
               case (st.work)
                  npd_pkg::WORK_SCALE:  state_ff <= S_DIVIDE;
                  npd_pkg::WORK_DIRECT: state_ff <= S_PLACE;
                  npd_pkg::WORK_RUN:    state_ff <= S_PLACE;
                  default:              state_ff <= S_END;
               endcase
            end
            S_DIVIDE: begin
               if (st.div_last) state_ff <= S_PLACE;
            end
            S_PLACE: begin
               state_ff <= st.emitted ? S_SEND : S_END;
            end
            S_SEND: begin
               if (rsp_ready) state_ff <= st.more ? S_PLACE : S_END;
            end
            S_END: begin
               state_ff <= S_WAIT;
            end
            default: state_ff <= S_WAIT;
         endcase
      end
   end

   assign req_ready    = (state_ff == S_WAIT);
   assign rsp_valid    = (state_ff == S_SEND);
   assign cmd.capture  = req_ready && req_valid;
   assign cmd.parse    = (state_ff == S_PARSE);
   assign cmd.div_step = (state_ff == S_DIVIDE);
   assign cmd.place    = (state_ff == S_PLACE);
   assign cmd.finish   = (state_ff == S_END);

   `NPD_ASSERT_SAME(a_one_side, clock, reset, req_ready, !rsp_valid)
   `NPD_ASSERT_NEXT(a_accept_parse, clock, reset, req_valid && req_ready, state_ff == S_PARSE)

endmodule

[hdl/npd_datapath.sv]
`include "assert_macros.svh"

module npd_datapath #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  npd_pkg::req_word_type req_word,
   output npd_pkg::rsp_word_type rsp_word,
   input  npd_pkg::cmd_type      cmd,
   output npd_pkg::status_type   st
);

   localparam int CW = COORD_BITS + 1;
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
   localparam logic [16:0] COORD_MAX17 = 17'((32'd1 << COORD_BITS) - 32'd1);
   localparam logic [16:0] TOKEN_CAP = 17'h1FFFF;

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [2:0] KIND_P1 = 3'd1;
   localparam logic [2:0] KIND_P2 = 3'd2;
   localparam logic [2:0] KIND_P3 = 3'd3;
   localparam logic [2:0] KIND_P4 = 3'd4;
   localparam logic [2:0] KIND_P6 = 3'd6;

   localparam logic [7:0] LEVEL_MAX = 8'd255;

   typedef enum logic [2:0] {
      PH_MAGIC_P,
      PH_MAGIC_DIGIT,
      PH_HEADER,
      PH_DATA,
      PH_IDLE
   } phase_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // token*10 + digit, saturating
   function automatic logic [16:0] accum(input logic [16:0] tok, input logic [7:0] c);
      logic [20:0] t;
      t = 21'(tok) * 21'd10 + 21'(c - CH_ZERO);
      return (t > 21'(TOKEN_CAP)) ? TOKEN_CAP : t[16:0];
   endfunction

   // captured byte
   logic [7:0] byte_ff, byte_in;
   logic       sof_ff, sof_in, eof_ff, eof_in;

   // parse state
   phase_type             phase_ff, phase_in;
   logic [2:0]            kind_ff, kind_in;
   logic [COORD_BITS-1:0] width_ff, width_in, height_ff, height_in;
   logic [15:0]           maxval_ff, maxval_in;
   logic [1:0]            left_ff, left_in;
   logic [16:0]           token_ff, token_in;
   logic                  hasdig_ff, hasdig_in;
   logic                  line_ff, line_in;
   logic                  comment_ff, comment_in;
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [1:0]            chan_ff, chan_in;
   logic [7:0]            red_ff, red_in, green_ff, green_in;
   logic [7:0]            high_ff, high_in;
   logic                  half_ff, half_in;

   // sample and divider
   logic [7:0]  samp_ff, samp_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] div_ff, div_in;
   logic [3:0]  step_ff, step_in;
   logic [8:0]  quo_ff, quo_in;
   logic [7:0]  bits_ff, bits_in;
   logic [3:0]  bits_left_ff, bits_left_in;

   npd_pkg::rsp_word_type out_ff, out_in;

   npd_pkg::work_type     work;
   logic                  emit_now, done_now, emit_req, scale_req, delim, ge;
   logic [16:0]           vs;
   logic [1:0]            total, pos;
   logic [7:0]            lvl, er, eg, eb;
   logic [8:0]            quo_next;
   logic [COORD_BITS-1:0] diff;

   always_comb begin
      byte_in = byte_ff;  sof_in = sof_ff;  eof_in = eof_ff;
      phase_in = phase_ff;  kind_in = kind_ff;
      width_in = width_ff;  height_in = height_ff;  maxval_in = maxval_ff;
      left_in = left_ff;  token_in = token_ff;  hasdig_in = hasdig_ff;
      line_in = line_ff;  comment_in = comment_ff;
      col_in = col_ff;  row_in = row_ff;  chan_in = chan_ff;
      red_in = red_ff;  green_in = green_ff;  high_in = high_ff;  half_in = half_ff;
      samp_in = samp_ff;  rem_in = rem_ff;  div_in = div_ff;  step_in = step_ff;
      quo_in = quo_ff;  bits_in = bits_ff;  bits_left_in = bits_left_ff;
      out_in = out_ff;
      work = npd_pkg::WORK_NONE;
      emit_now = 1'b0;  done_now = 1'b0;  emit_req = 1'b0;  scale_req = 1'b0;
      delim = 1'b0;  ge = 1'b0;  vs = '0;  total = '0;  pos = '0;
      lvl = '0;  er = '0;  eg = '0;  eb = '0;  quo_next = '0;  diff = '0;

      if (cmd.capture) begin
         byte_in = req_word.file_byte;
         sof_in  = req_word.start_of_file;
         eof_in  = req_word.end_of_file;
      end

      if (cmd.parse) begin
         if (sof_ff) begin
            phase_in = PH_MAGIC_P;  kind_in = '0;  width_in = '0;  height_in = '0;
            maxval_in = '0;  left_in = '0;  token_in = '0;  hasdig_in = 1'b0;
            line_in = 1'b0;  comment_in = 1'b0;  col_in = '0;  row_in = '0;
            chan_in = '0;  red_in = '0;  green_in = '0;  high_in = '0;  half_in = 1'b0;
         end
         bits_left_in = '0;
         delim = (byte_ff == CH_SPACE) || (byte_ff == CH_NL);
         case (phase_in)
            PH_MAGIC_P: begin
               phase_in = (byte_ff == CH_P) ? PH_MAGIC_DIGIT : PH_IDLE;
            end
            PH_MAGIC_DIGIT: begin
               if (byte_ff >= CH_ONE && byte_ff <= CH_SIX) begin
                  kind_in = byte_ff[2:0];
                  left_in = (kind_in == KIND_P1 || kind_in == KIND_P4) ? 2'd2 : 2'd3;
                  token_in = '0;  hasdig_in = 1'b0;  line_in = 1'b0;  comment_in = 1'b0;
                  phase_in = PH_HEADER;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_HEADER: begin
               if (comment_in) begin
                  if (byte_ff == CH_NL) begin
                     comment_in = 1'b0;
                     line_in = 1'b1;
                  end
               end else if (byte_ff == CH_HASH && line_in) begin
                  comment_in = 1'b1;
                  line_in = 1'b0;
               end else if (delim) begin
                  if (hasdig_in) begin
                     total = (kind_in == KIND_P1 || kind_in == KIND_P4) ? 2'd2 : 2'd3;
                     pos = total - left_in;
                     if (pos == 2'd0) begin
                        width_in = (token_in > COORD_MAX17) ? COORD_MAX
                                                            : token_in[COORD_BITS-1:0];
                     end else if (pos == 2'd1) begin
                        height_in = (token_in > COORD_MAX17) ? COORD_MAX
                                                             : token_in[COORD_BITS-1:0];
                     end else begin
                        maxval_in = (token_in > 17'hFFFF) ? 16'hFFFF : token_in[15:0];
                     end
                     left_in = left_in - 2'd1;
                     if (left_in == 2'd0) begin
                        phase_in = (width_in == '0 || height_in == '0) ? PH_IDLE : PH_DATA;
                        col_in = '0;  row_in = '0;  chan_in = '0;  half_in = 1'b0;
                     end
                  end
                  token_in = '0;
                  hasdig_in = 1'b0;
                  line_in = (byte_ff == CH_NL);
               end else begin
                  line_in = 1'b0;
                  if (is_digit(byte_ff)) begin
                     token_in = accum(token_in, byte_ff);
                     hasdig_in = 1'b1;
                  end
               end
            end
            PH_DATA: begin
               case (kind_in)
                  KIND_P1: begin
                     if (!delim) begin
                        samp_in = (byte_ff == CH_ONE) ? 8'd0 : LEVEL_MAX;
                        work = npd_pkg::WORK_DIRECT;
                     end
                  end
                  KIND_P2, KIND_P3: begin
                     if (!delim && is_digit(byte_ff)) begin
                        token_in = accum(token_in, byte_ff);
                        hasdig_in = 1'b1;
                     end
                     // a delimiter or the last byte of the file ends the token
                     if (delim || eof_ff) begin
                        if (hasdig_in) begin
                           vs = token_in;
                           scale_req = 1'b1;
                        end
                        token_in = '0;
                        hasdig_in = 1'b0;
                     end
                  end
                  KIND_P4: begin
                     diff = width_in - col_in;
                     bits_left_in = (diff > COORD_BITS'(8)) ? 4'd8 : 4'(diff);
                     bits_in = byte_ff;
                     work = npd_pkg::WORK_RUN;
                  end
                  default: begin
                     if (maxval_in > 16'd255) begin
                        if (!half_in) begin
                           high_in = byte_ff;
                           half_in = 1'b1;
                        end else begin
                           vs = {1'b0, high_in, byte_ff};
                           half_in = 1'b0;
                           scale_req = 1'b1;
                        end
                     end else begin
                        vs = {9'd0, byte_ff};
                        scale_req = 1'b1;
                     end
                  end
               endcase
            end
            default: ;
         endcase
         if (scale_req) begin
            if (maxval_in == '0) begin
               samp_in = (vs != '0) ? LEVEL_MAX : 8'd0;
               work = npd_pkg::WORK_DIRECT;
            end else begin
               rem_in = {vs, 8'd0} - 25'(vs);
               div_in = {maxval_in, 8'd0};
               step_in = 4'd8;
               quo_in = '0;
               work = npd_pkg::WORK_SCALE;
            end
         end
      end

      // restoring division, one quotient bit per cycle; bit 8 flags overflow
      if (cmd.div_step) begin
         ge = (rem_ff >= 25'(div_ff));
         if (ge) rem_in = rem_ff - 25'(div_ff);
         quo_next = {quo_ff[7:0], ge};
         quo_in = quo_next;
         div_in = div_ff >> 1;
         step_in = step_ff - 4'd1;
         if (step_ff == 4'd0) samp_in = quo_next[8] ? LEVEL_MAX : quo_next[7:0];
      end

      if (cmd.place) begin
         lvl = samp_ff;
         if (kind_ff == KIND_P4) begin
            lvl = bits_ff[7] ? 8'd0 : LEVEL_MAX;
            bits_in = bits_ff << 1;
            bits_left_in = bits_left_ff - 4'd1;
         end
         if (kind_ff == KIND_P3 || kind_ff == KIND_P6) begin
            case (chan_ff)
               2'd0: begin
                  red_in = lvl;
                  chan_in = 2'd1;
               end
               2'd1: begin
                  green_in = lvl;
                  chan_in = 2'd2;
               end
               default: begin
                  chan_in = 2'd0;
                  emit_req = 1'b1;
                  er = red_ff;  eg = green_ff;  eb = lvl;
               end
            endcase
         end else begin
            emit_req = 1'b1;
            er = lvl;  eg = lvl;  eb = lvl;
         end
         if (emit_req && phase_ff == PH_DATA) begin
            emit_now = 1'b1;
            done_now = (CW'(col_ff) + 1'b1 == CW'(width_ff)) &&
                       (CW'(row_ff) + 1'b1 == CW'(height_ff));
            out_in.column = 16'(col_ff);
            out_in.row = 16'(row_ff);
            out_in.red = er;
            out_in.green = eg;
            out_in.blue = eb;
            out_in.image_kind = kind_ff;
            out_in.image_width = 16'(width_ff);
            out_in.image_height = 16'(height_ff);
            out_in.image_complete = done_now;
            out_in.last_in_run = !(kind_ff == KIND_P4 && bits_left_in != '0 && !done_now);
            if (CW'(col_ff) + 1'b1 >= CW'(width_ff)) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (done_now) phase_in = PH_IDLE;
         end
      end

      if (cmd.finish && eof_ff) begin
         phase_in = PH_MAGIC_P;  kind_in = '0;  width_in = '0;  height_in = '0;
         maxval_in = '0;  left_in = '0;  token_in = '0;  hasdig_in = 1'b0;
         line_in = 1'b0;  comment_in = 1'b0;  col_in = '0;  row_in = '0;
         chan_in = '0;  red_in = '0;  green_in = '0;  high_in = '0;  half_in = 1'b0;
         bits_left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC_P;  kind_ff <= '0;  width_ff <= '0;  height_ff <= '0;
         maxval_ff <= '0;  left_ff <= '0;  token_ff <= '0;  hasdig_ff <= 1'b0;
         line_ff <= 1'b0;  comment_ff <= 1'b0;  col_ff <= '0;  row_ff <= '0;
         chan_ff <= '0;  red_ff <= '0;  green_ff <= '0;  high_ff <= '0;
         half_ff <= 1'b0;  step_ff <= '0;  bits_left_ff <= '0;
      end else begin
         phase_ff <= phase_in;  kind_ff <= kind_in;  width_ff <= width_in;
         height_ff <= height_in;  maxval_ff <= maxval_in;  left_ff <= left_in;
         token_ff <= token_in;  hasdig_ff <= hasdig_in;  line_ff <= line_in;
         comment_ff <= comment_in;  col_ff <= col_in;  row_ff <= row_in;
         chan_ff <= chan_in;  red_ff <= red_in;  green_ff <= green_in;
         high_ff <= high_in;  half_ff <= half_in;  step_ff <= step_in;
         bits_left_ff <= bits_left_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;  sof_ff <= sof_in;  eof_ff <= eof_in;
      samp_ff <= samp_in;  rem_ff <= rem_in;  div_ff <= div_in;
      quo_ff <= quo_in;  bits_ff <= bits_in;  out_ff <= out_in;
   end

   assign rsp_word    = out_ff;
   assign st.work     = work;
   assign st.div_last = (step_ff == 4'd0);
   assign st.emitted  = emit_now;
   assign st.more     = (kind_ff == KIND_P4) && (bits_left_ff != '0) && (phase_ff == PH_DATA);

   `NPD_ASSERT_NEXT(a_done_idle, clock, reset, emit_now && done_now, phase_ff == PH_IDLE)
   `NPD_ASSERT_SAME(a_run_kind, clock, reset, bits_left_ff != 4'd0, kind_ff == KIND_P4)

endmodule

[hdl/netpbm_pixel_decoder_unit.sv]
// Netpbm (P1..P6) decoder: takes a file one byte per req word and returns one
// RGB pixel per rsp word, with its column, row, the magic digit and the header
// width/height. start_of_file restarts the parse; end_of_file ends a pending
// ASCII sample and returns the parser to waiting for a magic. Bad magic yields
// no pixels; bytes after the last pixel are dropped. Samples scale to
// floor(v*255/maxval), saturating at 255. One byte is taken at a time: each
// byte is parsed; a sample is then scaled if needed by the bit-serial quotient
// unit (one quotient bit per cycle) and placed, and each pixel waits for rsp
// ready before the next. A P4 byte gives up to eight pixels. COORD_BITS sets the
// internal size of the position counters and of width/height, which saturate
// at 2^COORD_BITS-1; the port fields stay 16 bits.
module netpbm_pixel_decoder_unit #(
   parameter int COORD_BITS = 16
) (
   input logic     clock,
   input logic     reset,
   npd_req_if.sink   req_ch,
   npd_rsp_if.source rsp_ch
);

   npd_pkg::cmd_type    cmd;
   npd_pkg::status_type st;

   // sequencer: one byte in flight, result held until taken
   npd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // header parser, sample decode, scaler and pixel register
   npd_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_ch.word),
      .rsp_word (rsp_ch.word),
      .cmd      (cmd),
      .st       (st)
   );

endmodule
